>>> sv/spu_pkg.sv
// ----------------------------------------------------------------------------
// Spark particle updater package
// Shared sizes, codes, item records and fixed-point helpers.
// ----------------------------------------------------------------------------
package spu_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_PARTICLES = 64;
    localparam int SLOT_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

    // Command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // Result queue on the output side.
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_SPAN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROOP_RATE = 2'd2;

    localparam logic [14:0] LIFE_SPAN_RESET  = 15'd500;
    localparam logic [15:0] SPEED_GAIN_RESET = 16'd3355;
    localparam logic [9:0]  DROOP_RATE_RESET = 10'd49;
    localparam logic signed [15:0] LIFE_RESET = 16'sd500;

    // Angle constants.
    localparam logic signed [21:0] PI_Q13      = 22'sd25736;
    localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629714;
    localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam int                 CORDIC_STEPS = 24;

    typedef enum logic [1:0] {
        ACT_SPAWN   = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef struct packed {
        logic [14:0] life_span;
        logic [15:0] speed_gain;
        logic [9:0]  droop_rate;
    } t_cfg;

    typedef struct packed {
        t_action            action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] heading;
        logic signed [15:0] incline;
        logic [9:0]         elapsed;
        logic [19:0]        drop;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] heading;
        logic signed [15:0] incline;
    } t_part;

    typedef struct packed {
        logic [5:0]         slot;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] out_incline;
        logic               valid_res;
        logic               status;
        logic               expired;
        logic               last;
    } t_res;

    // Rotation angle of CORDIC step i in Q4.28.
    function automatic logic signed [32:0] atan_q28(input logic [4:0] i);
        logic signed [32:0] a;
        case (i)
            5'd0:    a = 33'sd210828714;
            5'd1:    a = 33'sd124459457;
            5'd2:    a = 33'sd65760959;
            5'd3:    a = 33'sd33381290;
            5'd4:    a = 33'sd16755422;
            5'd5:    a = 33'sd8385879;
            5'd6:    a = 33'sd4193963;
            5'd7:    a = 33'sd2097109;
            5'd8:    a = 33'sd1048571;
            5'd9:    a = 33'sd524287;
            default: a = 33'sd1 <<< (5'd28 - i);
        endcase
        return a;
    endfunction

    // Saturate to the 32 bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> sv/spu_front.sv
// ----------------------------------------------------------------------------
// Spark particle updater front part
// Accepts items, decodes the action and queues commands for the back part.
// ----------------------------------------------------------------------------
module spu_front import spu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_heading,
    input  logic signed [14:0] i_incline,
    input  logic [9:0]         i_elapsed_ms,
    input  logic [9:0]         i_droop_rate,
    input  logic               i_cmd_pop,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd
);

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0] r_wp;
    logic [CMDQ_PW-1:0] r_rp;
    logic [CMDQ_CW-1:0] r_cnt;
    t_cmd               cmd_in;
    logic               wr;
    logic               rd;

    // The inclination drop is worked out here so the back part need not.
    always_comb begin
        cmd_in.action  = t_action'(i_action);
        cmd_in.pos_x   = i_pos_x;
        cmd_in.pos_y   = i_pos_y;
        cmd_in.pos_z   = i_pos_z;
        cmd_in.heading = i_heading;
        cmd_in.incline = {i_incline[14], i_incline};
        cmd_in.elapsed = i_elapsed_ms;
        cmd_in.drop    = i_droop_rate * i_elapsed_ms;
    end

    assign full        = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

>>> sv/spu_cordic.sv
// ----------------------------------------------------------------------------
// Spark particle updater sine and cosine unit
// Iterative rotation CORDIC, one step per cycle, Q2.30 results.
// ----------------------------------------------------------------------------
module spu_cordic import spu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [32:0] r_z;
    logic [4:0]         r_step;
    logic               r_flip;
    logic               r_run;
    logic               r_done;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    logic signed [32:0] z0;
    logic signed [32:0] z1;
    logic signed [32:0] z2;
    logic               flip;
    logic signed [32:0] ang;
    logic signed [33:0] n_x;
    logic signed [33:0] n_y;
    logic signed [32:0] n_z;
    logic signed [33:0] x_f;
    logic signed [33:0] y_f;

    // Wrap the angle into one turn, then fold it into the right half plane.
    always_comb begin
        z0 = {{2{i_angle[15]}}, i_angle, 15'b0};
        z1 = z0;
        if (z1 > PI_Q28) begin
            z1 = z1 - TWO_PI_Q28;
        end
        if (z1 < -PI_Q28) begin
            z1 = z1 + TWO_PI_Q28;
        end
        z2   = z1;
        flip = 1'b0;
        if (z1 > HALF_PI_Q28) begin
            z2   = z1 - PI_Q28;
            flip = 1'b1;
        end else if (z1 < -HALF_PI_Q28) begin
            z2   = z1 + PI_Q28;
            flip = 1'b1;
        end
    end

    always_comb begin
        ang = atan_q28(r_step);
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_step);
            n_y = r_y + (r_x >>> r_step);
            n_z = r_z - ang;
        end else begin
            n_x = r_x + (r_y >>> r_step);
            n_y = r_y - (r_x >>> r_step);
            n_z = r_z + ang;
        end
        x_f = r_flip ? -n_x : n_x;
        y_f = r_flip ? -n_y : n_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_step == STEP_LAST)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= z2;
            r_flip <= flip;
            r_step <= '0;
        end else if (r_run) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_step <= r_step + 1'b1;
            if (r_step == STEP_LAST) begin
                r_cos <= x_f[31:0];
                r_sin <= y_f[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

>>> sv/spu_back.sv
// ----------------------------------------------------------------------------
// Spark particle updater back part
// Sequencer over the particle table, life and speed, and the result queue.
// ----------------------------------------------------------------------------
module spu_back import spu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic        pop,
    output logic        empty,
    output t_res        o_res
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_FIND   = 13'b0000000000010,
        S_SPWR   = 13'b0000000000100,
        S_LIFE   = 13'b0000000001000,
        S_SQRT   = 13'b0000000010000,
        S_VMUL   = 13'b0000000100000,
        S_TSTART = 13'b0000001000000,
        S_SCAN   = 13'b0000010000000,
        S_READ   = 13'b0000100000000,
        S_CORD   = 13'b0001000000000,
        S_PM2    = 13'b0010000000000,
        S_WRITE  = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [SLOT_W-1:0]   r_idx;
    logic                r_active [MAX_PARTICLES];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_emitted;
    logic signed [15:0]  r_life;
    logic                r_rej;
    logic [31:0]         r_sq_n;
    logic [31:0]         r_sq_r;
    logic [31:0]         r_sq_bit;
    logic [25:0]         r_p1;
    logic [25:0]         r_v;
    logic signed [58:0]  r_pch;
    logic signed [58:0]  r_psh;
    logic signed [58:0]  r_psi;
    logic signed [60:0]  r_tx;
    logic signed [60:0]  r_tz;
    logic signed [31:0]  r_ny;
    logic signed [15:0]  r_ninc;
    t_part               r_mem [MAX_PARTICLES];
    t_part               r_rd;

    t_res                r_oq [RESQ_DEPTH];
    logic [RESQ_PW-1:0]  r_owp;
    logic [RESQ_PW-1:0]  r_orp;
    logic [RESQ_CW-1:0]  r_ocnt;

    logic                res_full;
    logic                res_push;
    t_res                res_in;
    logic                mem_we;
    t_part               mem_wd;
    logic [5:0]          slot6;
    logic [SLOT_W+5:0]   slot_ext;

    logic signed [16:0]  life_diff;
    logic signed [15:0]  life_new;
    logic [31:0]         sq_sum;
    logic [41:0]         v_prod;
    logic                h_done;
    logic                i_done;
    logic signed [31:0]  sh;
    logic signed [31:0]  ch;
    logic signed [31:0]  si;
    logic signed [31:0]  ci;
    logic signed [58:0]  pch;
    logic signed [58:0]  psh;
    logic signed [58:0]  psi;
    logic signed [60:0]  tx;
    logic signed [60:0]  tz;
    logic signed [33:0]  ny_sum;
    logic signed [33:0]  nx_sum;
    logic signed [33:0]  nz_sum;
    logic signed [21:0]  inc_d;
    logic                cord_start;

    assign cord_start = (r_state == S_READ);

    spu_cordic u_cord_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (r_rd.heading),
        .o_done  (h_done),
        .o_sin   (sh),
        .o_cos   (ch)
    );

    spu_cordic u_cord_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (r_rd.incline),
        .o_done  (i_done),
        .o_sin   (si),
        .o_cos   (ci)
    );

    // Arithmetic between the sequencer's registers.
    always_comb begin
        life_diff = $signed({r_life[15], r_life}) - $signed({7'b0, r_cmd.elapsed});
        life_new  = (life_diff < -17'sd32768) ? -16'sd32768 : life_diff[15:0];
        sq_sum    = r_sq_r + r_sq_bit;
        v_prod    = r_p1 * r_sq_r[15:0];
        pch       = $signed({1'b0, r_v}) * ch;
        psh       = $signed({1'b0, r_v}) * sh;
        psi       = $signed({1'b0, r_v}) * si;
        tx        = $signed(r_pch[58:30]) * ci;
        tz        = $signed(r_psh[58:30]) * ci;
        ny_sum    = $signed(r_rd.y) + $signed(r_psi[58:30]);
        nx_sum    = $signed(r_rd.x) + $signed(r_tx[60:30]);
        nz_sum    = $signed(r_rd.z) - $signed(r_tz[60:30]);
        inc_d     = $signed(r_rd.incline) - $signed({2'b0, r_cmd.drop});
        slot_ext  = {6'b0, r_idx};
        slot6     = slot_ext[5:0];
    end

    assign res_full = (r_ocnt == RESQ_CW'(RESQ_DEPTH));

    // Result and table write for the current state.
    always_comb begin
        res_push = 1'b0;
        mem_we   = 1'b0;
        res_in   = '0;
        mem_wd   = r_rd;
        res_in.expired = r_life[15];
        unique case (r_state)
            S_SPWR: begin
                mem_we         = !res_full;
                res_push       = !res_full;
                mem_wd.x       = r_cmd.pos_x;
                mem_wd.y       = r_cmd.pos_y;
                mem_wd.z       = r_cmd.pos_z;
                mem_wd.heading = r_cmd.heading;
                mem_wd.incline = r_cmd.incline;
                res_in.slot        = slot6;
                res_in.out_x       = r_cmd.pos_x;
                res_in.out_y       = r_cmd.pos_y;
                res_in.out_z       = r_cmd.pos_z;
                res_in.out_incline = r_cmd.incline;
                res_in.valid_res   = 1'b1;
                res_in.last        = 1'b1;
            end
            S_WRITE: begin
                mem_we         = !res_full;
                res_push       = !res_full;
                mem_wd.x       = sat32(nx_sum);
                mem_wd.y       = r_ny;
                mem_wd.z       = sat32(nz_sum);
                mem_wd.incline = r_ninc;
                res_in.slot        = slot6;
                res_in.out_x       = sat32(nx_sum);
                res_in.out_y       = r_ny;
                res_in.out_z       = sat32(nz_sum);
                res_in.out_incline = r_ninc;
                res_in.valid_res   = 1'b1;
                res_in.last        = (CNT_W'(r_emitted + 1'b1) == r_count);
            end
            S_EMIT: begin
                res_push      = !res_full;
                res_in.status = r_rej;
                res_in.last   = 1'b1;
            end
            default: begin
                res_push = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_life  <= LIFE_RESET;
            for (int k = 0; k < MAX_PARTICLES; k++) begin
                r_active[k] <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.action)
                            ACT_SPAWN: begin
                                r_state <= (r_count >= CNT_W'(MAX_PARTICLES)) ? S_EMIT
                                                                              : S_FIND;
                            end
                            ACT_TICK: begin
                                r_state <= S_LIFE;
                            end
                            ACT_RESTART: begin
                                for (int k = 0; k < MAX_PARTICLES; k++) begin
                                    r_active[k] <= 1'b0;
                                end
                                r_count <= '0;
                                r_life  <= $signed({1'b0, i_cfg.life_span});
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    if (!r_active[r_idx]) begin
                        r_state <= S_SPWR;
                    end
                end
                S_SPWR: begin
                    if (!res_full) begin
                        r_active[r_idx] <= 1'b1;
                        r_count         <= r_count + 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_LIFE: begin
                    r_life  <= life_new;
                    r_state <= (life_new > 16'sd0) ? S_SQRT : S_TSTART;
                end
                S_SQRT: begin
                    if (r_sq_bit[0]) begin
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    r_state <= S_TSTART;
                end
                S_TSTART: begin
                    r_state <= (r_count == '0) ? S_EMIT : S_SCAN;
                end
                S_SCAN: begin
                    if (r_active[r_idx]) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (h_done && i_done) begin
                        r_state <= S_PM2;
                    end
                end
                S_PM2: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!res_full) begin
                        r_state <= (CNT_W'(r_emitted + 1'b1) == r_count) ? S_IDLE : S_SCAN;
                    end
                end
                S_EMIT: begin
                    if (!res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd     <= i_cmd;
                r_idx     <= '0;
                r_emitted <= '0;
                r_rej     <= (i_cmd.action == ACT_SPAWN);
            end
            S_FIND: begin
                if (r_active[r_idx]) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_LIFE: begin
                r_sq_n   <= {1'b0, life_new[14:0], 16'b0};
                r_sq_r   <= '0;
                r_sq_bit <= 32'h4000_0000;
                r_p1     <= r_cmd.elapsed * i_cfg.speed_gain;
                r_v      <= '0;
            end
            S_SQRT: begin
                if (r_sq_n >= sq_sum) begin
                    r_sq_n <= r_sq_n - sq_sum;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            S_VMUL: begin
                r_v <= v_prod[41:16];
            end
            S_SCAN: begin
                if (!r_active[r_idx]) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_CORD: begin
                r_pch <= pch;
                r_psh <= psh;
                r_psi <= psi;
            end
            S_PM2: begin
                r_tx   <= tx;
                r_tz   <= tz;
                r_ny   <= sat32(ny_sum);
                r_ninc <= (inc_d < -PI_Q13) ? 16'(-PI_Q13) : inc_d[15:0];
            end
            S_WRITE: begin
                if (!res_full) begin
                    r_emitted <= r_emitted + 1'b1;
                    r_idx     <= r_idx + 1'b1;
                end
            end
            default: begin
                r_rej <= r_rej;
            end
        endcase
    end

    // Particle table: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wd;
        end
        r_rd <= r_mem[r_idx];
    end

    // Result queue.
    assign empty = (r_ocnt == '0);
    assign o_res = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop && !empty) begin
                r_orp <= r_orp + 1'b1;
            end
            if (res_push && !(pop && !empty)) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!res_push && pop && !empty) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owp] <= res_in;
        end
    end

endmodule

>>> sv/spark_particle_updater_core.sv
// ----------------------------------------------------------------------------
// Spark particle updater core
// Keeps a table of spark particles and moves them on each time tick.
// ----------------------------------------------------------------------------
// Sequence: a spawn steps the find state over each occupied slot below the
// free one, then writes the new particle; a restart or idle item goes straight
// to the emit state; a tick updates life, runs the square root and the speed
// product when life is left, then for each active particle reads it, waits for
// the iterative CORDIC unit, multiplies and writes it, stepping over free slots.
// Throughput is one item at a time in the back part; the command queue
// accepts up to two items ahead. Synchronous active-low reset empties both
// queues, frees every slot and reloads life to 500 and the registers' defaults.
module spark_particle_updater_core import spu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Item input side.
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_action,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic signed [15:0]    i_heading,
    input  logic signed [14:0]    i_incline,
    input  logic [9:0]            i_elapsed_ms,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Result side.
    output logic                  empty,
    input  logic                  pop,
    output logic [5:0]            o_slot,
    output logic signed [31:0]    o_out_x,
    output logic signed [31:0]    o_out_y,
    output logic signed [31:0]    o_out_z,
    output logic signed [15:0]    o_out_incline,
    output logic                  o_valid_res,
    output logic                  o_status,
    output logic                  o_expired,
    output logic                  o_last
);

    // The configuration registers live here and are shared by both parts.
    // Writes to an index beyond the list are ignored.
    t_cfg r_cfg;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.life_span  <= LIFE_SPAN_RESET;
            r_cfg.speed_gain <= SPEED_GAIN_RESET;
            r_cfg.droop_rate <= DROOP_RATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIFE_SPAN:  r_cfg.life_span  <= i_cfg_data[14:0];
                CFG_SPEED_GAIN: r_cfg.speed_gain <= i_cfg_data;
                CFG_DROOP_RATE: r_cfg.droop_rate <= i_cfg_data[9:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The front part decodes each item and works out the inclination drop;
    // its queue lets new items be taken while the back part is busy.
    spu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_heading    (i_heading),
        .i_incline    (i_incline),
        .i_elapsed_ms (i_elapsed_ms),
        .i_droop_rate (r_cfg.droop_rate),
        .i_cmd_pop    (cmd_pop),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    // The back part owns the table, the shared life and the result queue.
    spu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .o_res       (res)
    );

    assign o_slot        = res.slot;
    assign o_out_x       = res.out_x;
    assign o_out_y       = res.out_y;
    assign o_out_z       = res.out_z;
    assign o_out_incline = res.out_incline;
    assign o_valid_res   = res.valid_res;
    assign o_status      = res.status;
    assign o_expired     = res.expired;
    assign o_last        = res.last;

endmodule

>>> sv/spu_checker.sv
// ----------------------------------------------------------------------------
// Spark particle updater checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module spu_checker import spu_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic [1:0]            i_action,
    input logic signed [31:0]    i_pos_x,
    input logic signed [31:0]    i_pos_y,
    input logic signed [31:0]    i_pos_z,
    input logic signed [15:0]    i_heading,
    input logic signed [14:0]    i_incline,
    input logic [9:0]            i_elapsed_ms,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  empty,
    input logic                  pop,
    input logic [5:0]            o_slot,
    input logic signed [31:0]    o_out_x,
    input logic signed [31:0]    o_out_y,
    input logic signed [31:0]    o_out_z,
    input logic signed [15:0]    o_out_incline,
    input logic                  o_valid_res,
    input logic                  o_status,
    input logic                  o_expired,
    input logic                  o_last
);

    // After reset both queues are empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A result that reports no particle carries zero payload.
    a_blank_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_valid_res |-> o_slot == 6'd0 && o_out_x == 32'sd0 &&
            o_out_y == 32'sd0 && o_out_z == 32'sd0 && o_out_incline == 16'sd0)
        else $error("blank result carries payload");

    // A rejected spawn is a lone, non-particle result.
    a_reject_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status |-> o_last && !o_valid_res)
        else $error("rejected spawn is not a lone blank result");

    // A reported inclination never drops below minus pi.
    a_incline_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_valid_res |-> o_out_incline >= -16'sd25736)
        else $error("inclination below clamp");

    // A result not taken stays on the ports.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_x) && $stable(o_slot) &&
            $stable(o_last))
        else $error("waiting result changed");

endmodule

bind spark_particle_updater_core spu_checker u_spu_checker (.*);

>>> verif/spu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spark particle updater checker
// Watches the item and result queues, keeps its own copy of the particle
// table and the registers, works out the results of every accepted item and
// compares them field by field with what the block delivers.
// ----------------------------------------------------------------------------
module spu_tb_checker import spu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_heading,
    input  logic signed [14:0] i_incline,
    input  logic [9:0]         i_elapsed_ms,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               empty,
    input  logic               pop,
    input  logic [5:0]         o_slot,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic signed [31:0] o_out_z,
    input  logic signed [15:0] o_out_incline,
    input  logic               o_valid_res,
    input  logic               o_status,
    input  logic               o_expired,
    input  logic               o_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);

    localparam longint ANGLE_PI   = 843314857;
    localparam longint ANGLE_HALF = 421657428;
    localparam longint GAIN_K     = 652032874;

    // Own copy of the table and the registers.
    logic signed [31:0] part_x [MAX_PARTICLES];
    logic signed [31:0] part_y [MAX_PARTICLES];
    logic signed [31:0] part_z [MAX_PARTICLES];
    logic signed [15:0] part_head [MAX_PARTICLES];
    logic signed [15:0] part_inc [MAX_PARTICLES];
    logic               part_live [MAX_PARTICLES];
    int                 live_count;
    int                 life_left;
    logic [14:0]        cfg_life;
    logic [15:0]        cfg_gain;
    logic [9:0]         cfg_droop;

    t_res expected_results [$];
    int   fails;

    assign o_fail_count   = fails;
    assign o_pending      = expected_results.size();

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root_q8(input longint n);
        longint r, b;
        r = 0;
        b = 64'd1 << 30;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Sine and cosine in Q2.30 by the same 24 step rotation as the block.
    task automatic rotate_angle(input logic signed [15:0] a, output longint sn,
                                output longint cs);
        longint z, x, y, t, step_ang;
        bit     flip;
        z = longint'(a) * 32768;
        x = GAIN_K;
        y = 0;
        flip = 0;
        if (z > ANGLE_PI) z -= 2 * ANGLE_PI;
        if (z < -ANGLE_PI) z += 2 * ANGLE_PI;
        if (z > ANGLE_HALF) begin
            z -= ANGLE_PI;
            flip = 1;
        end else if (z < -ANGLE_HALF) begin
            z += ANGLE_PI;
            flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            step_ang = longint'(atan_q28(5'(i)));
            if (z >= 0) begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                x = t;
                z -= step_ang;
            end else begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                x = t;
                z += step_ang;
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endtask

    function automatic t_res blank_result(input bit status, input bit last);
        t_res r;
        r = '0;
        r.status  = status;
        r.last    = last;
        r.expired = (life_left < 0);
        return r;
    endfunction

    task automatic predict_item(input t_action act);
        t_res   r;
        int     free_slot, n, drop;
        longint speed, sh, ch, si, ci, t, inc;
        case (act)
            ACT_SPAWN: begin
                free_slot = -1;
                for (int i = 0; i < MAX_PARTICLES; i++)
                    if (!part_live[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0) begin
                    expected_results.push_back(blank_result(1'b1, 1'b1));
                end else begin
                    part_x[free_slot]    = i_pos_x;
                    part_y[free_slot]    = i_pos_y;
                    part_z[free_slot]    = i_pos_z;
                    part_head[free_slot] = i_heading;
                    part_inc[free_slot]  = 16'(i_incline);
                    part_live[free_slot] = 1'b1;
                    live_count++;
                    r = blank_result(1'b0, 1'b1);
                    r.slot        = 6'(free_slot);
                    r.out_x       = i_pos_x;
                    r.out_y       = i_pos_y;
                    r.out_z       = i_pos_z;
                    r.out_incline = 16'(i_incline);
                    r.valid_res   = 1'b1;
                    expected_results.push_back(r);
                end
            end
            ACT_TICK: begin
                life_left -= int'(i_elapsed_ms);
                if (life_left < -32768) life_left = -32768;
                drop  = int'(cfg_droop) * int'(i_elapsed_ms);
                speed = 0;
                if (life_left > 0)
                    speed = (longint'(i_elapsed_ms) * cfg_gain
                             * root_q8(longint'(life_left) << 16)) >> 16;
                n = 0;
                for (int i = 0; i < MAX_PARTICLES; i++) begin
                    if (part_live[i]) begin
                        rotate_angle(part_head[i], sh, ch);
                        rotate_angle(part_inc[i], si, ci);
                        t = floor_shift(floor_shift(speed * ch, 30) * ci, 30);
                        part_x[i] = 32'(clamp32(longint'(part_x[i]) + t));
                        part_y[i] = 32'(clamp32(longint'(part_y[i])
                                    + floor_shift(speed * si, 30)));
                        t = floor_shift(floor_shift(speed * sh, 30) * ci, 30);
                        part_z[i] = 32'(clamp32(longint'(part_z[i]) - t));
                        inc = longint'(part_inc[i]) - drop;
                        if (inc < -25736) inc = -25736;
                        part_inc[i] = 16'(inc);
                        r = blank_result(1'b0, 1'b0);
                        r.slot        = 6'(i);
                        r.out_x       = part_x[i];
                        r.out_y       = part_y[i];
                        r.out_z       = part_z[i];
                        r.out_incline = part_inc[i];
                        r.valid_res   = 1'b1;
                        expected_results.push_back(r);
                        n++;
                    end
                end
                if (n == 0) expected_results.push_back(blank_result(1'b0, 1'b1));
                else expected_results[$].last = 1'b1;
            end
            ACT_RESTART: begin
                for (int i = 0; i < MAX_PARTICLES; i++) part_live[i] = 1'b0;
                live_count = 0;
                life_left  = int'(cfg_life);
                expected_results.push_back(blank_result(1'b0, 1'b1));
            end
            default: begin
                expected_results.push_back(blank_result(1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic compare_result();
        t_res want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no item pending", 1, 0);
        end else begin
            want = expected_results.pop_front();
            if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
            if (o_out_x !== want.out_x) report_mismatch("out_x", o_out_x, want.out_x);
            if (o_out_y !== want.out_y) report_mismatch("out_y", o_out_y, want.out_y);
            if (o_out_z !== want.out_z) report_mismatch("out_z", o_out_z, want.out_z);
            if (o_out_incline !== want.out_incline)
                report_mismatch("out_incline", o_out_incline, want.out_incline);
            if (o_valid_res !== want.valid_res)
                report_mismatch("valid_res", o_valid_res, want.valid_res);
            if (o_status !== want.status) report_mismatch("status", o_status, want.status);
            if (o_expired !== want.expired)
                report_mismatch("expired", o_expired, want.expired);
            if (o_last !== want.last) report_mismatch("last", o_last, want.last);
        end
    endtask

    initial begin
        fails = 0;
        o_results_seen = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PARTICLES; i++) part_live[i] = 1'b0;
            live_count = 0;
            life_left  = 500;
            cfg_life   = LIFE_SPAN_RESET;
            cfg_gain   = SPEED_GAIN_RESET;
            cfg_droop  = DROOP_RATE_RESET;
            expected_results.delete();
        end else begin
            if (pop && !empty) begin
                compare_result();
                o_results_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIFE_SPAN:  cfg_life  = i_cfg_data[14:0];
                    CFG_SPEED_GAIN: cfg_gain  = i_cfg_data;
                    CFG_DROOP_RATE: cfg_droop = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (push && !full) predict_item(t_action'(i_action));
        end
    end

endmodule

>>> verif/tb_spark_particle_updater_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spark particle updater testbench
// Drives spawn, tick, restart and idle items into the core under several
// register settings and idling patterns, while a checker beside the core
// predicts every result and compares it with what comes out.
// ----------------------------------------------------------------------------
module tb_spark_particle_updater_core;
    import spu_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_action = ACT_NOP;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic signed [15:0] i_heading = '0;
    logic signed [14:0] i_incline = '0;
    logic [9:0]         i_elapsed_ms = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_LIFE_SPAN;
    logic [15:0]        i_cfg_data = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [5:0]         o_slot;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic signed [15:0] o_out_incline;
    logic               o_valid_res, o_status, o_expired, o_last;
    int                 fail_count, pending, results_seen;

    // Idling percentages for each side; the current phase sets them.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  cycle_count = 0;
    int  items_sent = 0;

    always #1 i_clk = ~i_clk;

    spark_particle_updater_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_action(i_action), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .i_heading(i_heading), .i_incline(i_incline),
        .i_elapsed_ms(i_elapsed_ms),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .empty(empty), .pop(pop),
        .o_slot(o_slot), .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_out_incline(o_out_incline), .o_valid_res(o_valid_res),
        .o_status(o_status), .o_expired(o_expired), .o_last(o_last)
    );

    spu_tb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_action(i_action), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .i_heading(i_heading), .i_incline(i_incline),
        .i_elapsed_ms(i_elapsed_ms),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .empty(empty), .pop(pop),
        .o_slot(o_slot), .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_out_incline(o_out_incline), .o_valid_res(o_valid_res),
        .o_status(o_status), .o_expired(o_expired), .o_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    // The receiver pops at random according to the current stall rate.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Hands one item to the block. Random idle cycles are placed before it,
    // and push stays high across back-to-back items without a drop.
    task automatic send_item(input t_action act, input logic signed [31:0] px,
                             input logic signed [31:0] py,
                             input logic signed [31:0] pz,
                             input logic signed [15:0] hd,
                             input logic signed [14:0] inc,
                             input logic [9:0] ms);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_action     <= act;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_pos_z      <= pz;
        i_heading    <= hd;
        i_incline    <= inc;
        i_elapsed_ms <= ms;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    // Lets the block drain completely, then some further cycles so that no
    // item is still in progress.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_heading();
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    function automatic logic signed [14:0] rand_incline();
        return 15'($signed($urandom_range(25736)) - 12868);
    endfunction

    // Random mix: mostly spawns and short ticks, restarts now and then so
    // that life is refreshed and the table both fills and empties.
    task automatic random_items(input int count);
        int sel;
        logic [9:0] ms;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            ms  = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(40));
            if (sel < 50) begin
                send_item(ACT_SPAWN, $urandom, $urandom, $urandom,
                          rand_heading(), rand_incline(), 10'($urandom));
            end else if (sel < 80) begin
                send_item(ACT_TICK, $urandom, $urandom, $urandom,
                          16'($urandom), 15'($urandom), ms);
            end else if (sel < 92) begin
                send_item(ACT_RESTART, $urandom, $urandom, $urandom,
                          16'($urandom), 15'($urandom), 10'($urandom));
            end else begin
                send_item(ACT_NOP, $urandom, $urandom, $urandom,
                          16'($urandom), 15'($urandom), 10'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset defaults: extreme positions and angles,
        // every action, a tick with an empty table and an expiring life.
        send_item(ACT_TICK, 0, 0, 0, 0, 0, 10'd5);
        send_item(ACT_SPAWN, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                  16'sd25736, 15'sd12868, 0);
        send_item(ACT_SPAWN, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                  -16'sd25736, -15'sd12868, 10'h3FF);
        send_item(ACT_SPAWN, 0, 0, 0, 0, 0, 0);
        send_item(ACT_SPAWN, 32'h00010000, -32'sh00010000, 32'h12345678,
                  16'sd12868, 15'sd6434, 0);
        send_item(ACT_SPAWN, 1, 2, 3, 16'h7FFF, 15'h3FFF, 0);
        send_item(ACT_SPAWN, 1, 2, 3, 16'h8000, 15'h4000, 0);
        send_item(ACT_TICK, 0, 0, 0, 0, 0, 10'd100);
        send_item(ACT_TICK, 0, 0, 0, 0, 0, 10'd0);
        send_item(ACT_NOP, 0, 0, 0, 0, 0, 10'd7);
        send_item(ACT_TICK, 0, 0, 0, 0, 0, 10'h3FF);
        send_item(ACT_TICK, 0, 0, 0, 0, 0, 10'h3FF);
        send_item(ACT_RESTART, 0, 0, 0, 0, 0, 0);
        // Fill the table and try one spawn too many.
        for (int i = 0; i < MAX_PARTICLES + 1; i++)
            send_item(ACT_SPAWN, $urandom, $urandom, $urandom,
                      rand_heading(), rand_incline(), 0);
        send_item(ACT_TICK, 0, 0, 0, 0, 0, 10'd20);
        send_item(ACT_RESTART, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // Extremes of the registers, then random settings; the phases take turns
        // among four idling patterns.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_LIFE_SPAN, 16'h7FFF);
                    write_reg(CFG_SPEED_GAIN, 16'hFFFF);
                    write_reg(CFG_DROOP_RATE, 16'h03FF);
                end
                1: begin
                    write_reg(CFG_LIFE_SPAN, 16'd0);
                    write_reg(CFG_SPEED_GAIN, 16'd0);
                    write_reg(CFG_DROOP_RATE, 16'd0);
                end
                default: begin
                    write_reg(CFG_LIFE_SPAN, 16'($urandom));
                    write_reg(CFG_SPEED_GAIN, 16'($urandom));
                    write_reg(CFG_DROOP_RATE, 16'($urandom));
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // A restart makes the new life span take effect.
            send_item(ACT_RESTART, 0, 0, 0, 0, 0, 0);
            random_items(28);
            // Hold the sender until everything so far has come back.
            push <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
            random_items(28);
            wait_drained();
        end

        $display("covered %0d items and %0d results over six register settings",
                 items_sent, results_seen);
        $display("with table fill, overflow, expiry and mixed idling on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
